@@ rtl/core/eprt_pkg.sv @@
// Shared types, constants and register codes for the echo probe reply tracker.
package eprt_pkg;

    // Duplicate bitmap geometry: slots are packed into rows of the seen memory
    localparam int SEEN_SLOTS    = 512;
    localparam int SEEN_ROW_BITS = 16;
    localparam int SEEN_ROWS     = SEEN_SLOTS / SEEN_ROW_BITS;
    localparam int SLOT_W        = $clog2(SEEN_SLOTS);
    localparam int BIT_W         = $clog2(SEEN_ROW_BITS);
    localparam int ROW_W         = $clog2(SEEN_ROWS);

    // Protocol constants
    localparam logic [31:0] ONE_SEC_US     = 32'd1000000;
    localparam logic [16:0] ECHO_HDR_BYTES = 17'd8;
    localparam logic [15:0] STAMP_BYTES    = 16'd4;
    localparam logic [7:0]  MCAST_PREFIX   = 8'hFF;
    localparam int          MAX_TRIP_SHIFT = 19;
    localparam int          MAX_TRIP_HI_W  = 32 - MAX_TRIP_SHIFT;

    // Stream and configuration widths
    localparam int IN_TDATA_W  = 248;
    localparam int OUT_TDATA_W = 312;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Event kinds carried in tuser
    localparam logic FUNC_SEND  = 1'b0;
    localparam logic FUNC_REPLY = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ECHO_ID      = 3'd0,
        CFG_PAYLOAD_LEN  = 3'd1,
        CFG_PROBE_COUNT  = 3'd2,
        CFG_HOST_ADDR_HI = 3'd3,
        CFG_HOST_ADDR_LO = 3'd4,
        CFG_INTERVAL_US  = 3'd5,
        CFG_TIMEOUT_US   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] echo_id;
        logic [15:0] payload_len;
        logic [15:0] probe_count;
        logic [63:0] host_addr_hi;
        logic [63:0] host_addr_lo;
        logic [31:0] interval_us;
        logic [31:0] timeout_us;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        echo_id:      16'h0053,
        payload_len:  16'd4,
        probe_count:  16'd3,
        host_addr_hi: 64'd0,
        host_addr_lo: 64'd0,
        interval_us:  ONE_SEC_US,
        timeout_us:   ONE_SEC_US
    };

    // Input payload, last member in the lowest bits
    typedef struct packed {
        logic [63:0] src_addr_lo;
        logic [63:0] src_addr_hi;
        logic [31:0] sent_stamp;
        logic [15:0] reply_seq;
        logic [15:0] reply_ident;
        logic        is_echo_reply;
        logic [15:0] msg_size;
        logic [31:0] now_us;
    } in_data_t;

    localparam int IN_DATA_W = $bits(in_data_t);

    // Result payload, last member in the lowest bits
    typedef struct packed {
        logic [63:0] rtt_sum;
        logic [31:0] rtt_max;
        logic [31:0] rtt_min;
        logic [31:0] dup_total;
        logic [31:0] recv_total;
        logic [31:0] sent_total;
        logic [31:0] trip_time_us;
        logic        duplicate;
        logic        accepted;
        logic [31:0] timer_us;
        logic        finish_next;
        logic [15:0] probe_seq;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    typedef logic [SEEN_ROW_BITS-1:0] row_t;

    // Write-back request into the seen memory
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        row_t             data;
    } wr_req_t;

endpackage

@@ rtl/core/eprt_seen_map.sv @@
// Seen-slot memory: row storage, per-row valid bits and write-back forwarding.
module eprt_seen_map (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [eprt_pkg::ROW_W-1:0] rd_addr,
    input  eprt_pkg::wr_req_t         wr,
    output eprt_pkg::row_t            rd_data
);
    import eprt_pkg::*;

    row_t             mem [SEEN_ROWS];
    logic [SEEN_ROWS-1:0] row_valid_reg;
    row_t             rdata_reg;
    logic             rvalid_reg;
    logic [ROW_W-1:0] raddr_reg;
    logic             last_wr_en_reg;
    logic [ROW_W-1:0] last_wr_addr_reg;
    row_t             last_wr_data_reg;

    // Row storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Hold the last write-back for rows read in the same cycle it lands
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            last_wr_addr_reg <= wr.addr;
            last_wr_data_reg <= wr.data;
        end
        if (rd_en)
        begin
            raddr_reg <= rd_addr;
        end
    end

    // Valid bits: a row never written reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            rvalid_reg     <= 1'b0;
            last_wr_en_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_valid_reg[wr.addr] <= 1'b1;
                last_wr_en_reg         <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Forward the newest write when it hits the row being read
    always_comb
    begin
        if (last_wr_en_reg && (last_wr_addr_reg == raddr_reg))
        begin
            rd_data = last_wr_data_reg;
        end
        else if (rvalid_reg)
        begin
            rd_data = rdata_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

@@ rtl/core/eprt_track.sv @@
// Session statistics: event decode, reply filter, counters and trip time tracking.
module eprt_track (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       commit,
    input  logic                       func,
    input  eprt_pkg::in_data_t         data,
    input  logic [eprt_pkg::SLOT_W-1:0] slot,
    input  eprt_pkg::cfg_t             cfg,
    input  eprt_pkg::row_t             row,
    output eprt_pkg::wr_req_t          wr,
    output eprt_pkg::result_t          res
);
    import eprt_pkg::*;

    logic [31:0] sent_reg, sent_next;
    logic [31:0] recv_reg, recv_next;
    logic [31:0] dup_reg,  dup_next;
    logic [31:0] min_reg,  min_next;
    logic [31:0] max_reg,  max_next;
    logic [63:0] sum_reg,  sum_next;

    logic [BIT_W-1:0]         bit_sel;
    row_t                     bit_mask;
    logic                     slot_hit;
    logic [32:0]              sent_inc;
    logic                     last_probe;
    logic [MAX_TRIP_HI_W-1:0] max_hi;
    logic [32:0]              wait_prod;
    logic [31:0]              final_wait;
    logic                     host_mcast;
    logic                     same_host;
    logic                     reply_ok;
    logic                     has_stamp;
    logic [31:0]              trip;

    assign bit_sel  = slot[BIT_W-1:0];
    assign bit_mask = row_t'(1) << bit_sel;
    assign slot_hit = row[bit_sel];

    // Final wait after the last probe
    assign sent_inc   = {1'b0, sent_reg} + 33'd1;
    assign last_probe = sent_inc >= {17'd0, cfg.probe_count};
    assign max_hi     = max_reg[31:MAX_TRIP_SHIFT];
    assign wait_prod  = 33'(max_hi) * 33'(ONE_SEC_US);

    always_comb
    begin
        if (recv_reg == 32'd0)
        begin
            final_wait = cfg.timeout_us;
        end
        else if (wait_prod == 33'd0)
        begin
            final_wait = ONE_SEC_US;
        end
        else if (wait_prod[32])
        begin
            final_wait = '1;
        end
        else
        begin
            final_wait = wait_prod[31:0];
        end
    end

    // Reply filter
    assign host_mcast = cfg.host_addr_hi[63:56] == MCAST_PREFIX;
    assign same_host  = (data.src_addr_hi == cfg.host_addr_hi)
                     && (data.src_addr_lo == cfg.host_addr_lo);
    assign reply_ok   = ({1'b0, data.msg_size} >= ({1'b0, cfg.payload_len} + ECHO_HDR_BYTES))
                     && data.is_echo_reply
                     && (data.reply_ident == cfg.echo_id)
                     && (host_mcast || same_host);
    assign has_stamp  = cfg.payload_len >= STAMP_BYTES;
    assign trip       = data.now_us - data.sent_stamp;

    // Next state, write-back row and result for the item in flight
    always_comb
    begin
        sent_next = sent_reg;
        recv_next = recv_reg;
        dup_next  = dup_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        sum_next  = sum_reg;
        wr.en     = 1'b0;
        wr.addr   = slot[SLOT_W-1:BIT_W];
        wr.data   = row;
        res       = '0;

        if (func == FUNC_SEND)
        begin
            wr.en           = commit;
            wr.data         = row & ~bit_mask;
            sent_next       = sent_reg + 32'd1;
            res.probe_seq   = sent_reg[15:0];
            res.finish_next = last_probe;
            res.timer_us    = last_probe ? final_wait : cfg.interval_us;
        end
        else if (reply_ok)
        begin
            res.accepted = 1'b1;
            if (has_stamp)
            begin
                sum_next         = sum_reg + {32'd0, trip};
                min_next         = (trip < min_reg) ? trip : min_reg;
                max_next         = (trip > max_reg) ? trip : max_reg;
                res.trip_time_us = trip;
            end
            if (slot_hit)
            begin
                dup_next      = dup_reg + 32'd1;
                res.duplicate = 1'b1;
            end
            else
            begin
                wr.en     = commit;
                wr.data   = row | bit_mask;
                recv_next = recv_reg + 32'd1;
            end
        end

        res.sent_total = sent_next;
        res.recv_total = recv_next;
        res.dup_total  = dup_next;
        res.rtt_min    = min_next;
        res.rtt_max    = max_next;
        res.rtt_sum    = sum_next;
    end

    // Advance the session state when the item leaves the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= '0;
            recv_reg <= '0;
            dup_reg  <= '0;
            min_reg  <= '1;
            max_reg  <= '0;
            sum_reg  <= '0;
        end
        else if (commit)
        begin
            sent_reg <= sent_next;
            recv_reg <= recv_next;
            dup_reg  <= dup_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

@@ rtl/core/echo_probe_reply_tracker.sv @@
// Top level: stream ports, configuration registers, pipeline control and output register.
// Path: stage register, then output register. Throughput, unless m_axis stalls a full output:
// one event per cycle; each event does one read-modify-write of a seen-memory row,
// with the previous write-back forwarded so back-to-back hits on one row stay in order.
// Reset: configuration returns to its defaults, counters clear, the minimum trip goes to all
// ones, and per-row valid bits make the whole seen map read as zero at once (no clearing pass).
module echo_probe_reply_tracker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_us, msg_size, is_echo_reply, reply_ident, reply_seq, sent_stamp,
    // src_addr_hi, src_addr_lo, zero pad
    input  logic [eprt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // probe_seq, finish_next, timer_us, accepted, duplicate, trip_time_us, sent_total,
    // recv_total, dup_total, rtt_min, rtt_max, rtt_sum, zero pad
    output logic [eprt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [eprt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eprt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import eprt_pkg::*;

    cfg_t             cfg_reg;
    logic             s1_valid_reg;
    logic             s1_func_reg;
    in_data_t         s1_data_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [SLOT_W-1:0] send_slot_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    in_data_t         in_data;
    logic             in_xfer;
    logic             s1_adv;
    logic [SLOT_W-1:0] in_slot;
    row_t             row;
    wr_req_t          wr;
    result_t          res;

    assign in_data = in_data_t'(s_axis_tdata[IN_DATA_W-1:0]);
    assign in_slot = (s_axis_tuser == FUNC_SEND) ? send_slot_reg
                                                 : in_data.reply_seq[SLOT_W-1:0];

    // Handshakes: the stage moves when the output register is free or being emptied
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ECHO_ID:      cfg_reg.echo_id      <= cfg_data[15:0];
                CFG_PAYLOAD_LEN:  cfg_reg.payload_len  <= cfg_data[15:0];
                CFG_PROBE_COUNT:  cfg_reg.probe_count  <= cfg_data[15:0];
                CFG_HOST_ADDR_HI: cfg_reg.host_addr_hi <= cfg_data;
                CFG_HOST_ADDR_LO: cfg_reg.host_addr_lo <= cfg_data;
                CFG_INTERVAL_US:  cfg_reg.interval_us  <= cfg_data[31:0];
                CFG_TIMEOUT_US:   cfg_reg.timeout_us   <= cfg_data[31:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Pipeline control: stage valid, send slot pointer, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            send_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (in_xfer && (s_axis_tuser == FUNC_SEND))
            begin
                send_slot_reg <= send_slot_reg + SLOT_W'(1);
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the accepted item and the finished result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_func_reg <= s_axis_tuser;
            s1_data_reg <= in_data;
            s1_slot_reg <= in_slot;
        end
        if (s1_adv)
        begin
            out_reg <= res;
        end
    end

    eprt_seen_map u_seen_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_addr (in_slot[SLOT_W-1:BIT_W]),
        .wr      (wr),
        .rd_data (row)
    );

    eprt_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (s1_adv),
        .func   (s1_func_reg),
        .data   (s1_data_reg),
        .slot   (s1_slot_reg),
        .cfg    (cfg_reg),
        .row    (row),
        .wr     (wr),
        .res    (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_reg};

    // A blocked stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_axis_tready)
            |=> (s1_valid_reg && $stable(s1_data_reg) && $stable(s1_slot_reg)))
        else $error("stalled stage lost its item");

    // A finished item always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("committed item did not reach the output");

    // Input back-pressure only when both stages are full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without cause");

    // A duplicate mark only on an accepted reply
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.duplicate) |-> out_reg.accepted)
        else $error("duplicate flagged on a rejected reply");

endmodule

@@ sim/echo_session_checker.sv @@
// Checker for the echo probe reply tracker: watches all channels, predicts each report, compares.
module echo_session_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // now_us, msg_size, is_echo_reply, reply_ident, reply_seq, sent_stamp,
    // src_addr_hi, src_addr_lo, zero pad
    input  logic [eprt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                             s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // probe_seq, finish_next, timer_us, accepted, duplicate, trip_time_us, sent_total,
    // recv_total, dup_total, rtt_min, rtt_max, rtt_sum, zero pad
    input  logic [eprt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [eprt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eprt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               pending
);
    import eprt_pkg::*;

    localparam int          SLOT_BITS  = 9;
    localparam int          SLOTS      = 1 << SLOT_BITS;
    localparam logic [16:0] HDR_LEN    = 17'd8;
    localparam logic [15:0] STAMP_LEN  = 16'd4;
    localparam logic [31:0] ONE_SECOND = 32'd1000000;
    localparam logic [7:0]  MCAST_TOP  = 8'hFF;

    // Register copies
    logic [15:0] id_reg;
    logic [15:0] plen_reg;
    logic [15:0] pcount_reg;
    logic [63:0] host_hi_reg;
    logic [63:0] host_lo_reg;
    logic [31:0] interval_reg;
    logic [31:0] timeout_reg;

    // Session state
    logic        slot_seen [SLOTS];
    logic [31:0] probes_sent;
    logic [31:0] uniq_replies;
    logic [31:0] dup_replies;
    logic [31:0] trip_floor;
    logic [31:0] trip_peak;
    logic [63:0] trip_total;

    // Reports still owed by the block, oldest first
    result_t session_reports [$];

    task automatic reset_session();
        id_reg       = 16'h0053;
        plen_reg     = 16'd4;
        pcount_reg   = 16'd3;
        host_hi_reg  = 64'd0;
        host_lo_reg  = 64'd0;
        interval_reg = ONE_SECOND;
        timeout_reg  = ONE_SECOND;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_seen[i] = 1'b0;
        end
        probes_sent  = '0;
        uniq_replies = '0;
        dup_replies  = '0;
        trip_floor   = '1;
        trip_peak    = '0;
        trip_total   = '0;
        session_reports.delete();
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        case (idx)
            CFG_ECHO_ID:      id_reg       = val[15:0];
            CFG_PAYLOAD_LEN:  plen_reg     = val[15:0];
            CFG_PROBE_COUNT:  pcount_reg   = val[15:0];
            CFG_HOST_ADDR_HI: host_hi_reg  = val;
            CFG_HOST_ADDR_LO: host_lo_reg  = val;
            CFG_INTERVAL_US:  interval_reg = val[31:0];
            CFG_TIMEOUT_US:   timeout_reg  = val[31:0];
            default: ;
        endcase
    endtask

    // Update the session for one event and build the report it owes
    task automatic advance_session(input logic func, input in_data_t d, output result_t r);
        logic [32:0]          next_count;
        logic [63:0]          wait_prod;
        logic [31:0]          trip;
        logic [SLOT_BITS-1:0] slot;
        logic                 host_mcast;
        logic                 from_host;
        logic                 passes;
        r = '0;
        if (func == FUNC_SEND)
        begin
            slot_seen[probes_sent[SLOT_BITS-1:0]] = 1'b0;
            next_count = {1'b0, probes_sent} + 33'd1;
            if (next_count < {17'd0, pcount_reg})
            begin
                r.finish_next = 1'b0;
                r.timer_us    = interval_reg;
            end
            else
            begin
                r.finish_next = 1'b1;
                // last wait: timeout with no replies, else scaled from the peak trip
                if (uniq_replies == 32'd0)
                    r.timer_us = timeout_reg;
                else
                begin
                    wait_prod = {51'd0, trip_peak[31:19]} * 64'd1000000;
                    if (wait_prod == 64'd0)
                        r.timer_us = ONE_SECOND;
                    else if (wait_prod > 64'hFFFF_FFFF)
                        r.timer_us = '1;
                    else
                        r.timer_us = wait_prod[31:0];
                end
            end
            r.probe_seq = probes_sent[15:0];
            probes_sent = probes_sent + 32'd1;
        end
        else
        begin
            host_mcast = (host_hi_reg[63:56] == MCAST_TOP);
            from_host  = (d.src_addr_hi == host_hi_reg) && (d.src_addr_lo == host_lo_reg);
            passes     = ({1'b0, d.msg_size} >= ({1'b0, plen_reg} + HDR_LEN))
                         && d.is_echo_reply && (d.reply_ident == id_reg)
                         && (host_mcast || from_host);
            if (passes)
            begin
                r.accepted = 1'b1;
                // measure trip only when the payload holds a stamp
                if (plen_reg >= STAMP_LEN)
                begin
                    trip       = d.now_us - d.sent_stamp;
                    trip_total = trip_total + {32'd0, trip};
                    if (trip < trip_floor)
                        trip_floor = trip;
                    if (trip > trip_peak)
                        trip_peak = trip;
                    r.trip_time_us = trip;
                end
                slot = d.reply_seq[SLOT_BITS-1:0];
                if (slot_seen[slot])
                begin
                    dup_replies = dup_replies + 32'd1;
                    r.duplicate = 1'b1;
                end
                else
                begin
                    slot_seen[slot] = 1'b1;
                    uniq_replies    = uniq_replies + 32'd1;
                end
            end
        end
        r.sent_total = probes_sent;
        r.recv_total = uniq_replies;
        r.dup_total  = dup_replies;
        r.rtt_min    = trip_floor;
        r.rtt_max    = trip_peak;
        r.rtt_sum    = trip_total;
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    // Track transfers on every channel
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
            reset_session();
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[RESULT_W-1:0];
                if (session_reports.size() == 0)
                begin
                    $error("report transfer with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = session_reports.pop_front();
                    check_field("probe_seq",    want.probe_seq,    got.probe_seq);
                    check_field("finish_next",  want.finish_next,  got.finish_next);
                    check_field("timer_us",     want.timer_us,     got.timer_us);
                    check_field("accepted",     want.accepted,     got.accepted);
                    check_field("duplicate",    want.duplicate,    got.duplicate);
                    check_field("trip_time_us", want.trip_time_us, got.trip_time_us);
                    check_field("sent_total",   want.sent_total,   got.sent_total);
                    check_field("recv_total",   want.recv_total,   got.recv_total);
                    check_field("dup_total",    want.dup_total,    got.dup_total);
                    check_field("rtt_min",      want.rtt_min,      got.rtt_min);
                    check_field("rtt_max",      want.rtt_max,      got.rtt_max);
                    check_field("rtt_sum",      want.rtt_sum,      got.rtt_sum);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_session(s_axis_tuser, s_axis_tdata[IN_DATA_W-1:0], want);
                session_reports.push_back(want);
            end
        end
        pending = session_reports.size();
    end

endmodule

@@ sim/tb_echo_probe_reply_tracker.sv @@
// Testbench top for the echo probe reply tracker: clock, reset, stimulus and verdict.
module tb_echo_probe_reply_tracker;
    import eprt_pkg::*;

    localparam int                     CYCLE_LIMIT = 200000;
    localparam int                     HOLD_CYCLES = 400;
    localparam logic [CFG_INDEX_W-1:0] UNUSED_REG  = 3'd7;
    localparam logic [7:0]             MCAST_TOP   = 8'hFF;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     pending;

    // Settings the stimulus aims at
    logic [15:0] cur_echo_id = 16'h0053;
    logic [15:0] cur_payload = 16'd4;
    logic [63:0] cur_host_hi = 64'd0;
    logic [63:0] cur_host_lo = 64'd0;

    int unsigned probes_out    = 0;
    int          burst_left    = 0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;
    int          mode_left     = 0;
    rx_mode_t    rx_mode       = RX_OPEN;
    int          cycle_count   = 0;

    echo_probe_reply_tracker uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    echo_session_checker session_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            mode_left     <= 0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served  <= holds_served + 1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(8, 80);
            end
            else
                mode_left <= mode_left - 1;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ((mode_left % 8) < 5);
            endcase
        end
    end

    // Give up on a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("echo_probe_reply_tracker: mismatch");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write every register back to back, then the unused index
    task automatic load_config(input logic [15:0] id, input logic [15:0] plen,
                               input logic [15:0] pcount, input logic [63:0] hhi,
                               input logic [63:0] hlo, input logic [31:0] ivl,
                               input logic [31:0] tmo);
        write_reg(CFG_ECHO_ID,      {48'd0, id});
        write_reg(CFG_PAYLOAD_LEN,  {48'd0, plen});
        write_reg(CFG_PROBE_COUNT,  {48'd0, pcount});
        write_reg(CFG_HOST_ADDR_HI, hhi);
        write_reg(CFG_HOST_ADDR_LO, hlo);
        write_reg(CFG_INTERVAL_US,  {$urandom, ivl});
        write_reg(CFG_TIMEOUT_US,   {$urandom, tmo});
        write_reg(UNUSED_REG,       {$urandom, $urandom});
        cfg_valid   <= 1'b0;
        cur_echo_id = id;
        cur_payload = plen;
        cur_host_hi = hhi;
        cur_host_lo = hlo;
    endtask

    // Offer one event; start a new burst after a random gap when the old one runs out
    task automatic offer(input logic func, input in_data_t d);
        logic [IN_TDATA_W-1:0] word;
        int                    gap;
        word                 = '0;
        word[IN_DATA_W-1:0]  = d;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 12);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= func;
        do @(posedge clk); while (!s_axis_tready);
        if (func == FUNC_SEND)
            probes_out++;
    endtask

    // Pause the sender until every report is back
    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic scramble(output in_data_t d);
        d.now_us        = $urandom;
        d.msg_size      = 16'($urandom);
        d.is_echo_reply = 1'($urandom_range(0, 1));
        d.reply_ident   = 16'($urandom);
        d.reply_seq     = 16'($urandom);
        d.sent_stamp    = $urandom;
        d.src_addr_hi   = {$urandom, $urandom};
        d.src_addr_lo   = {$urandom, $urandom};
    endtask

    task automatic send_probe();
        in_data_t d;
        scramble(d);
        offer(FUNC_SEND, d);
    endtask

    // Reply passing every filter for payloads up to 0xFFF7, mostly to a recent probe
    task automatic make_good_reply(output in_data_t d);
        int unsigned back;
        logic [16:0] len;
        logic [31:0] trip;
        scramble(d);
        len             = {1'b0, cur_payload} + 17'd8 + 17'($urandom_range(0, 40));
        d.msg_size      = len[16] ? 16'hFFFF : len[15:0];
        d.is_echo_reply = 1'b1;
        d.reply_ident   = cur_echo_id;
        back            = $urandom_range(1, 12);
        if ($urandom_range(0, 7) == 0)
            d.reply_seq = 16'($urandom);
        else if (probes_out >= back)
            d.reply_seq = 16'(probes_out - back);
        else
            d.reply_seq = 16'($urandom_range(0, 600));
        trip         = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000000);
        d.sent_stamp = d.now_us - trip;
        if (!(cur_host_hi[63:56] == MCAST_TOP && $urandom_range(0, 1) == 1))
        begin
            d.src_addr_hi = cur_host_hi;
            d.src_addr_lo = cur_host_lo;
        end
    endtask

    task automatic timed_reply(input logic [15:0] seq, input logic [31:0] now,
                               input logic [31:0] stamp, output in_data_t d);
        make_good_reply(d);
        d.reply_seq  = seq;
        d.now_us     = now;
        d.sent_stamp = stamp;
    endtask

    // Break one filter condition; a source change breaks none for a multicast host
    task automatic make_broken_reply(output in_data_t d);
        logic [16:0] min_len;
        make_good_reply(d);
        min_len = {1'b0, cur_payload} + 17'd8;
        case ($urandom_range(0, 3))
            0: d.msg_size = (min_len > 17'hFFFF) ? 16'($urandom)
                                                 : 16'($urandom_range(0, min_len - 1));
            1: d.is_echo_reply = 1'b0;
            2: d.reply_ident = cur_echo_id ^ 16'($urandom_range(1, 65535));
            default:
            begin
                d.src_addr_hi = cur_host_hi ^ {$urandom, $urandom};
                d.src_addr_lo = cur_host_lo ^ 64'($urandom_range(1, 255));
            end
        endcase
    endtask

    task automatic run_random(input int count, input int send_pct);
        int       pick;
        in_data_t d;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < send_pct)
                send_probe();
            else if (pick < 85)
            begin
                make_good_reply(d);
                offer(FUNC_REPLY, d);
            end
            else if (pick < 95)
            begin
                make_broken_reply(d);
                offer(FUNC_REPLY, d);
            end
            else
            begin
                scramble(d);
                offer(logic'($urandom_range(0, 1)), d);
            end
        end
    endtask

    initial
    begin
        in_data_t d;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_SEND;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_ECHO_ID;
        cfg_data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: two probes on the interval, the third ends on the timeout
        repeat (3) send_probe();
        timed_reply(16'd0, 32'd5000, 32'd4000, d);
        offer(FUNC_REPLY, d);
        // short peak trip: last wait floors at one second
        send_probe();
        timed_reply(16'd0, 32'd700000, 32'd100000, d);
        offer(FUNC_REPLY, d);
        send_probe();
        // each filter on its own
        timed_reply(16'd1, 32'd50, 32'd0, d);
        d.msg_size = 16'd11;
        offer(FUNC_REPLY, d);
        timed_reply(16'd1, 32'd50, 32'd0, d);
        d.is_echo_reply = 1'b0;
        offer(FUNC_REPLY, d);
        timed_reply(16'd1, 32'd50, 32'd0, d);
        d.reply_ident = cur_echo_id ^ 16'hFFFF;
        offer(FUNC_REPLY, d);
        timed_reply(16'd1, 32'd50, 32'd0, d);
        d.src_addr_lo = 64'd1;
        offer(FUNC_REPLY, d);
        // sequence aliasing onto slot zero, top slot, stamp wrap
        timed_reply(16'd512, 32'd20, 32'd10, d);
        offer(FUNC_REPLY, d);
        timed_reply(16'hFFFF, 32'd5, 32'hFFFF_FFF0, d);
        offer(FUNC_REPLY, d);
        // zero trip, then all-ones trip at the largest message
        timed_reply(16'd1, 32'h1234_5678, 32'h1234_5678, d);
        offer(FUNC_REPLY, d);
        timed_reply(16'd2, 32'd0, 32'd1, d);
        d.msg_size = 16'hFFFF;
        offer(FUNC_REPLY, d);
        // huge peak trip: last wait saturates
        send_probe();
        timed_reply(16'd3, 32'd100, 32'd0, d);
        d.msg_size = 16'd12;
        offer(FUNC_REPLY, d);
        scramble(d);
        offer(FUNC_REPLY, d);
        scramble(d);
        offer(FUNC_SEND, d);
        timed_reply(16'd5, 32'd900, 32'd300, d);
        offer(FUNC_REPLY, d);
        send_probe();
        timed_reply(16'($urandom_range(0, 6)), $urandom, $urandom, d);
        offer(FUNC_REPLY, d);
        wait_for_reports();

        // Random settings with stamps
        load_config(16'($urandom), 16'($urandom_range(4, 64)), 16'($urandom_range(2, 40)),
                    {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
                    $urandom, $urandom_range(1, 32'hFFFF_FFFF));
        run_random(100, 40);
        wait_for_reports();

        // Upper extremes, multicast host, no stamp; a run of probes, then hold off reports
        load_config(16'hFFFF, 16'd0, 16'hFFFF, 64'hFF00_0000_0000_0000 | 64'($urandom),
                    64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        repeat (150) send_probe();
        hold_requests <= hold_requests + 1;
        run_random(120, 30);
        wait_for_reports();

        // Lower extremes: one-probe session, payload just short of a stamp
        load_config(16'd0, 16'd3, 16'd1, 64'hFEFF_FFFF_FFFF_FFFF, 64'd0,
                    32'hFFFF_FFFF, 32'd1);
        run_random(150, 40);
        wait_for_reports();

        // Longest payload: every reply falls short
        load_config(16'($urandom), 16'hFFFF, 16'($urandom_range(1, 65535)),
                    {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
                    $urandom, $urandom_range(1, 32'hFFFF_FFFF));
        run_random(30, 30);
        wait_for_reports();

        // Back to default identity, with a mid-phase drain
        load_config(16'h0053, 16'd8, 16'd20, {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF,
                    {$urandom, $urandom}, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
        run_random(120, 40);
        wait_for_reports();
        run_random(120, 40);
        wait_for_reports();

        repeat (12) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("echo_probe_reply_tracker: match");
        else
            $display("echo_probe_reply_tracker: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/eprt_pkg.sv
rtl/core/eprt_seen_map.sv
rtl/core/eprt_track.sv
rtl/core/echo_probe_reply_tracker.sv
sim/echo_session_checker.sv
sim/tb_echo_probe_reply_tracker.sv
